>>> hdl/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared constants, codes, types and helper functions of the palette color
// fader.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int PALETTE_DEPTH = 16;
  localparam int FRAC_BITS     = 8;
  localparam int CHANNELS      = 3;
  localparam int COLOR_W       = 24;
  localparam int LEVEL_W       = 10 + FRAC_BITS;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int SIZE_W        = $clog2(PALETTE_DEPTH + 1);
  localparam int DIV_CW        = $clog2(LEVEL_W + 1);
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  // item kinds
  localparam logic [1:0] KIND_TICK      = 2'd0;
  localparam logic [1:0] KIND_PAL_WRITE = 2'd1;
  localparam logic [1:0] KIND_START     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_STEP,
    ST_RAND,
    ST_PAL_WAIT,
    ST_PAL_TAKE,
    ST_DIV_LOAD,
    ST_DIV,
    ST_ADD
  } state_t;

  // eight steps of the galois lfsr
  function automatic logic [31:0] lfsr_advance(input logic [31:0] v);
    logic [31:0] s;
    s = v;
    for (int i = 0; i < 8; i++) begin
      s = (s >> 1) ^ (s[0] ? LFSR_MASK : 32'h0);
    end
    return s;
  endfunction

  // integer part of a level, clamped to 0..255
  function automatic logic [7:0] level_byte(input logic signed [LEVEL_W-1:0] v);
    logic [7:0] r;
    if (v[LEVEL_W-1]) begin
      r = 8'd0;
    end else if (|v[LEVEL_W-2:FRAC_BITS+8]) begin
      r = 8'hFF;
    end else begin
      r = v[FRAC_BITS+7:FRAC_BITS];
    end
    return r;
  endfunction

endpackage

>>> hdl/pcf_ram.sv
// ----------------------------------------------------------------------------
// pcf_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/palette_color_fader.sv
// ----------------------------------------------------------------------------
// palette_color_fader
// Tick-driven linear RGB cross-fader with palette or pseudo-random targets.
// ----------------------------------------------------------------------------
// One input transaction is worked on at a time. Palette writes, start commands
// and ignored kinds are taken in ST_IDLE alone. A tick passes through ST_TICK;
// a step goes on through ST_STEP and ST_ADD. A step that ends a segment loads a
// new target (three bytes from the lfsr in ST_RAND, or a palette RAM read in
// ST_PAL_WAIT and ST_PAL_TAKE) and then runs three parallel restoring
// dividers, one quotient bit per cycle over LEVEL_W bits. The tick that starts
// the fade fetches two colors before the divide.
// A finished result waits in the output register while the next transaction
// is accepted; a step stalls only if the previous result is still unread.
module palette_color_fader (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic [3:0]                        entry_index,
  input  logic [7:0]                        entry_red,
  input  logic [7:0]                        entry_green,
  input  logic [7:0]                        entry_blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic                              new_segment
);

  localparam int AW  = pcf_pkg::PAL_AW;
  localparam int SW  = pcf_pkg::SIZE_W;
  localparam int LW  = pcf_pkg::LEVEL_W;
  localparam int DCW = pcf_pkg::DIV_CW;
  localparam int NCH = pcf_pkg::CHANNELS;
  localparam int FB  = pcf_pkg::FRAC_BITS;

  logic [15:0] step_interval;
  logic [31:0] start_delay;
  logic [7:0]  step_count;
  logic [4:0]  palette_size;
  logic        random_mode;
  logic [31:0] random_seed;

  pcf_pkg::state_t state, state_next;

  logic [31:0]          elapsed;
  logic                 waiting;
  logic                 showing;
  logic [7:0]           steps_left;
  logic [AW-1:0]        pos;
  logic [AW-1:0]        rd_addr;
  logic signed [LW-1:0] level [NCH];
  logic signed [LW-1:0] inc [NCH];
  logic [23:0]          target;
  logic [23:0]          color_acc;
  logic [31:0]          lfsr;
  logic [1:0]           ch_cnt;
  logic                 first_pending;
  logic                 in_begin;
  logic                 fresh;
  logic [7:0]           rem [NCH];
  logic [LW-1:0]        mag [NCH];
  logic                 neg [NCH];
  logic [DCW-1:0]       div_cnt;

  logic                 in_fire;
  logic                 pal_we;
  logic [23:0]          pal_rdata;
  logic [7:0]           eff_count;
  logic [SW-1:0]        eff_size;
  logic [SW-1:0]        pos_ext;
  logic [SW-1:0]        pos_eff;
  logic [SW-1:0]        pos_inc;
  logic [SW-1:0]        pos_wrap;
  logic [31:0]          lfsr_adv;
  logic [23:0]          land_color;
  logic                 out_free;
  logic                 step_due;
  logic                 start_due;
  logic                 div_last;
  logic                 rand_last;
  logic [8:0]           trial [NCH];
  logic                 trial_ge [NCH];
  logic [8:0]           trial_sub [NCH];
  logic signed [LW:0]   diff [NCH];
  logic [LW:0]          diff_abs [NCH];
  logic signed [LW-1:0] level_sum [NCH];

  pcf_ram #(
    .WIDTH(pcf_pkg::COLOR_W),
    .DEPTH(pcf_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(AW'(entry_index)),
    .wdata({entry_red, entry_green, entry_blue}),
    .raddr(rd_addr),
    .rdata(pal_rdata)
  );

  assign in_ready  = (state == pcf_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign pal_we    = in_fire && (kind == pcf_pkg::KIND_PAL_WRITE) &&
                     (int'(entry_index) < pcf_pkg::PALETTE_DEPTH);
  assign eff_count = (step_count < 8'd2) ? 8'd2 : step_count;
  assign lfsr_adv  = pcf_pkg::lfsr_advance(lfsr);
  assign out_free  = !out_valid || out_ready;
  assign step_due  = showing && (elapsed > {16'd0, step_interval});
  assign start_due = waiting && (elapsed >= start_delay);
  assign div_last  = (div_cnt == DCW'(LW));
  assign rand_last = (ch_cnt == 2'd2);
  assign land_color = (state == pcf_pkg::ST_RAND) ? {color_acc[15:0], lfsr_adv[7:0]}
                                                  : pal_rdata;

  always_comb begin
    if (palette_size < 5'd2) begin
      eff_size = SW'(2);
    end else if (int'(palette_size) > pcf_pkg::PALETTE_DEPTH) begin
      eff_size = SW'(pcf_pkg::PALETTE_DEPTH);
    end else begin
      eff_size = SW'(palette_size);
    end
  end

  assign pos_ext  = SW'(pos);
  assign pos_eff  = (pos_ext < eff_size) ? pos_ext : '0;
  assign pos_inc  = pos_eff + SW'(1);
  assign pos_wrap = (pos_inc == eff_size) ? '0 : pos_inc;

  // divider lanes and level arithmetic
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      trial[ch]     = {rem[ch], mag[ch][LW-1]};
      trial_ge[ch]  = (trial[ch] >= {1'b0, eff_count});
      trial_sub[ch] = trial[ch] - {1'b0, eff_count};
      diff[ch]      = $signed({3'b000, target[(2-ch)*8 +: 8], {FB{1'b0}}}) -
                      $signed({level[ch][LW-1], level[ch]});
      diff_abs[ch]  = diff[ch][LW] ? (LW+1)'(-diff[ch]) : diff[ch];
      level_sum[ch] = level[ch] + inc[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pcf_pkg::ST_IDLE: begin
        if (in_fire && (kind == pcf_pkg::KIND_TICK)) begin
          state_next = pcf_pkg::ST_TICK;
        end
      end
      pcf_pkg::ST_TICK: begin
        if (start_due) begin
          state_next = random_mode ? pcf_pkg::ST_RAND : pcf_pkg::ST_PAL_WAIT;
        end else if (step_due) begin
          state_next = pcf_pkg::ST_STEP;
        end else begin
          state_next = pcf_pkg::ST_IDLE;
        end
      end
      pcf_pkg::ST_STEP: begin
        if (steps_left == 8'd0) begin
          state_next = random_mode ? pcf_pkg::ST_RAND : pcf_pkg::ST_PAL_WAIT;
        end else begin
          state_next = pcf_pkg::ST_ADD;
        end
      end
      pcf_pkg::ST_RAND: begin
        if (rand_last && !first_pending) begin
          state_next = pcf_pkg::ST_DIV_LOAD;
        end
      end
      pcf_pkg::ST_PAL_WAIT: begin
        state_next = pcf_pkg::ST_PAL_TAKE;
      end
      pcf_pkg::ST_PAL_TAKE: begin
        state_next = first_pending ? pcf_pkg::ST_PAL_WAIT : pcf_pkg::ST_DIV_LOAD;
      end
      pcf_pkg::ST_DIV_LOAD: begin
        state_next = pcf_pkg::ST_DIV;
      end
      pcf_pkg::ST_DIV: begin
        if (div_last) begin
          if (in_begin) begin
            state_next = step_due ? pcf_pkg::ST_STEP : pcf_pkg::ST_IDLE;
          end else begin
            state_next = pcf_pkg::ST_ADD;
          end
        end
      end
      pcf_pkg::ST_ADD: begin
        if (out_free) begin
          state_next = pcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pcf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval <= 16'd50;
      start_delay   <= 32'd0;
      step_count    <= 8'd2;
      palette_size  <= 5'd2;
      random_mode   <= 1'b1;
      random_seed   <= 32'd1;
      elapsed       <= 32'd0;
      waiting       <= 1'b0;
      showing       <= 1'b0;
      steps_left    <= 8'd0;
      pos           <= '0;
      rd_addr       <= '0;
      target        <= 24'd0;
      lfsr          <= 32'd1;
      ch_cnt        <= 2'd0;
      first_pending <= 1'b0;
      in_begin      <= 1'b0;
      fresh         <= 1'b0;
      div_cnt       <= '0;
      out_valid     <= 1'b0;
      for (int ch = 0; ch < NCH; ch++) begin
        level[ch] <= '0;
        inc[ch]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pcf_pkg::CFG_STEP_INTERVAL: step_interval <= cfg_data[15:0];
          pcf_pkg::CFG_START_DELAY:   start_delay   <= cfg_data[31:0];
          pcf_pkg::CFG_STEP_COUNT:    step_count    <= cfg_data[7:0];
          pcf_pkg::CFG_PALETTE_SIZE:  palette_size  <= cfg_data[4:0];
          pcf_pkg::CFG_RANDOM_MODE:   random_mode   <= cfg_data[0];
          pcf_pkg::CFG_RANDOM_SEED:   random_seed   <= cfg_data[31:0];
          default: ;
        endcase
      end

      if (state == pcf_pkg::ST_ADD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        pcf_pkg::ST_IDLE: begin
          if (in_fire) begin
            case (kind)
              pcf_pkg::KIND_TICK: begin
                if (elapsed != 32'hFFFF_FFFF) begin
                  elapsed <= elapsed + 32'd1;
                end
              end
              pcf_pkg::KIND_START: begin
                elapsed <= 32'd0;
                waiting <= 1'b1;
                lfsr    <= (random_seed != 32'd0) ? random_seed : 32'd1;
              end
              default: ;
            endcase
          end
        end
        pcf_pkg::ST_TICK: begin
          if (start_due) begin
            waiting       <= 1'b0;
            showing       <= 1'b1;
            in_begin      <= 1'b1;
            first_pending <= 1'b1;
            ch_cnt        <= 2'd0;
            rd_addr       <= '0;
            if (!random_mode) begin
              pos <= (eff_size == SW'(2)) ? '0 : AW'(2);
            end
          end
        end
        pcf_pkg::ST_STEP: begin
          elapsed <= 32'd0;
          if (steps_left == 8'd0) begin
            for (int ch = 0; ch < NCH; ch++) begin
              level[ch] <= $signed({2'b00, target[(2-ch)*8 +: 8], {FB{1'b0}}});
            end
            ch_cnt  <= 2'd0;
            rd_addr <= AW'(pos_eff);
            if (!random_mode) begin
              pos <= AW'(pos_wrap);
            end
          end else begin
            steps_left <= steps_left - 8'd1;
            fresh      <= 1'b0;
          end
        end
        pcf_pkg::ST_RAND: begin
          lfsr      <= lfsr_adv;
          color_acc <= {color_acc[15:0], lfsr_adv[7:0]};
          ch_cnt    <= rand_last ? 2'd0 : ch_cnt + 2'd1;
          if (rand_last) begin
            if (first_pending) begin
              first_pending <= 1'b0;
              for (int ch = 0; ch < NCH; ch++) begin
                level[ch] <= $signed({2'b00, land_color[(2-ch)*8 +: 8], {FB{1'b0}}});
              end
            end else begin
              target <= land_color;
            end
          end
        end
        pcf_pkg::ST_PAL_TAKE: begin
          if (first_pending) begin
            first_pending <= 1'b0;
            rd_addr       <= AW'(1);
            for (int ch = 0; ch < NCH; ch++) begin
              level[ch] <= $signed({2'b00, land_color[(2-ch)*8 +: 8], {FB{1'b0}}});
            end
          end else begin
            target <= land_color;
          end
        end
        pcf_pkg::ST_DIV_LOAD: begin
          div_cnt <= '0;
          for (int ch = 0; ch < NCH; ch++) begin
            rem[ch] <= 8'd0;
            mag[ch] <= diff_abs[ch][LW-1:0];
            neg[ch] <= diff[ch][LW];
          end
        end
        pcf_pkg::ST_DIV: begin
          if (div_last) begin
            for (int ch = 0; ch < NCH; ch++) begin
              inc[ch] <= neg[ch] ? -$signed(mag[ch]) : $signed(mag[ch]);
            end
            if (in_begin) begin
              in_begin   <= 1'b0;
              steps_left <= eff_count;
            end else begin
              steps_left <= eff_count - 8'd1;
              fresh      <= 1'b1;
            end
          end else begin
            div_cnt <= div_cnt + DCW'(1);
            for (int ch = 0; ch < NCH; ch++) begin
              rem[ch] <= trial_ge[ch] ? trial_sub[ch][7:0] : trial[ch][7:0];
              mag[ch] <= {mag[ch][LW-2:0], trial_ge[ch]};
            end
          end
        end
        pcf_pkg::ST_ADD: begin
          if (out_free) begin
            for (int ch = 0; ch < NCH; ch++) begin
              level[ch] <= level_sum[ch];
            end
            red         <= pcf_pkg::level_byte(level_sum[0]);
            green       <= pcf_pkg::level_byte(level_sum[1]);
            blue        <= pcf_pkg::level_byte(level_sum[2]);
            new_segment <= fresh;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
